// ----- rtl/core/capture_period_to_rpm_top_macros.svh -----
// Assertion macros shared by the capture tachometer RTL
`ifndef CAPTURE_PERIOD_TO_RPM_TOP_MACROS_SVH
`define CAPTURE_PERIOD_TO_RPM_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset
`define CP2RPM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define CP2RPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/cp2rpm_pkg.sv -----
// Constants and types for the capture tachometer
package cp2rpm_pkg;

    // Width of the free-running capture counter (16 to 32)
    localparam int COUNTER_BITS = 32;

    localparam int STAMP_W = 32;
    localparam int RATE_W  = 32;
    localparam int FREQ_W  = RATE_W + 8;
    localparam int SPEED_W = 46;

    // One quotient bit per divider step
    localparam int DIV_STEPS = FREQ_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [RATE_W-1:0]  RATE_RESET = RATE_W'(1000000);
    localparam logic [STAMP_W-1:0] CNT_MASK   =
        STAMP_W'((64'd1 << COUNTER_BITS) - 64'd1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_HOLD
    } t_state;

endpackage

// ----- rtl/core/capture_period_to_rpm_top.sv -----
// Sequence: an item that opens a pair gives no result; a pair-closing item runs 40 restoring
// divide steps, then its result is loaded into the output registers once the output is free.
// Input stalls after a closing item until its result is loaded, so no new item is taken while
// a pair is in work; the shared divide step yields one quotient bit per cycle. A zero period
// bypasses the divider and goes straight to the output load; an output stall lengthens the input stall.
// Reset (synchronous, active low): tick rate 1000000, pairing state, held period, output empty.
`include "capture_period_to_rpm_top_macros.svh"

module capture_period_to_rpm_top
    import cp2rpm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic [RATE_W-1:0]  i_cfg_data,
    // capture items
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_on_primary_channel,
    input  logic [STAMP_W-1:0] i_capture_stamp,
    // results
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [STAMP_W-1:0] o_period_ticks,
    output logic [FREQ_W-1:0]  o_frequency_q8,
    output logic [SPEED_W-1:0] o_speed_rpm_q8,
    output logic               o_zero_period
);

    t_state               r_state, n_state;
    logic [RATE_W-1:0]    r_rate, n_rate;
    logic                 r_awaiting, n_awaiting;
    logic [STAMP_W-1:0]   r_first, n_first;
    logic [STAMP_W-1:0]   r_held, n_held;
    logic [STAMP_W-1:0]   r_period, n_period;
    logic                 r_zero, n_zero;
    logic [STAMP_W-1:0]   r_rem, n_rem;
    logic [FREQ_W-1:0]    r_quot, n_quot;
    logic [STEP_W-1:0]    r_step, n_step;
    logic                 r_out_valid, n_out_valid;
    logic [STAMP_W-1:0]   r_o_period, n_o_period;
    logic [FREQ_W-1:0]    r_o_freq, n_o_freq;
    logic [SPEED_W-1:0]   r_o_speed, n_o_speed;
    logic                 r_o_zero, n_o_zero;

    logic [STAMP_W-1:0]   w_stamp;
    logic [STAMP_W-1:0]   w_pair_period;
    logic [STAMP_W:0]     w_rem_sh;
    logic [STAMP_W:0]     w_rem_diff;
    logic                 w_qbit;
    logic                 w_out_free;

    // Pairing arithmetic on the incoming stamp
    assign w_stamp       = i_capture_stamp & CNT_MASK;
    assign w_pair_period = (w_stamp != r_first) ? ((w_stamp - r_first) & CNT_MASK)
                                                : r_held;

    // Shared restoring divide step
    assign w_rem_sh   = {r_rem, r_quot[FREQ_W-1]};
    assign w_rem_diff = w_rem_sh - {1'b0, r_period};
    assign w_qbit     = !w_rem_diff[STAMP_W];

    assign w_out_free = !r_out_valid || !i_out_stall;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate      <= RATE_RESET;
            r_awaiting  <= 1'b0;
            r_first     <= '0;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_rate      <= n_rate;
            r_awaiting  <= n_awaiting;
            r_first     <= n_first;
            r_held      <= n_held;
            r_out_valid <= n_out_valid;
        end
    end

    // Divider datapath and output payload
    always_ff @(posedge i_clk) begin
        r_period   <= n_period;
        r_zero     <= n_zero;
        r_rem      <= n_rem;
        r_quot     <= n_quot;
        r_step     <= n_step;
        r_o_period <= n_o_period;
        r_o_freq   <= n_o_freq;
        r_o_speed  <= n_o_speed;
        r_o_zero   <= n_o_zero;
    end

    // Sequencer: next state and next register values
    always_comb begin
        n_state     = r_state;
        n_rate      = r_rate;
        n_awaiting  = r_awaiting;
        n_first     = r_first;
        n_held      = r_held;
        n_period    = r_period;
        n_zero      = r_zero;
        n_rem       = r_rem;
        n_quot      = r_quot;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        n_o_period  = r_o_period;
        n_o_freq    = r_o_freq;
        n_o_speed   = r_o_speed;
        n_o_zero    = r_o_zero;
        o_in_stall  = (r_state != ST_IDLE);

        if (i_cfg_we) begin
            n_rate = i_cfg_data;
        end

        // result taken downstream
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_on_primary_channel) begin
                    if (!r_awaiting) begin
                        n_first    = w_stamp;
                        n_awaiting = 1'b1;
                    end else begin
                        n_held     = w_pair_period;
                        n_period   = w_pair_period;
                        n_awaiting = 1'b0;
                        n_rem      = '0;
                        n_step     = '0;
                        if (w_pair_period == '0) begin
                            n_zero  = 1'b1;
                            n_quot  = '0;
                            n_state = ST_HOLD;
                        end else begin
                            n_zero  = 1'b0;
                            n_quot  = {r_rate, 8'd0};
                            n_state = ST_DIV;
                        end
                    end
                end
            end
            ST_DIV: begin
                n_rem  = w_qbit ? w_rem_diff[STAMP_W-1:0] : w_rem_sh[STAMP_W-1:0];
                n_quot = {r_quot[FREQ_W-2:0], w_qbit};
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_o_period  = r_period;
                    n_o_freq    = r_quot;
                    // times 60 = times 64 minus times 4
                    n_o_speed   = {r_quot, 6'd0} - {4'd0, r_quot, 2'd0};
                    n_o_zero    = r_zero;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid    = r_out_valid;
    assign o_period_ticks = r_o_period;
    assign o_frequency_q8 = r_o_freq;
    assign o_speed_rpm_q8 = r_o_speed;
    assign o_zero_period  = r_o_zero;

    // Checks
    `CP2RPM_ASSERT_NOW(a_rem_below_div, i_clk, i_rst_n, r_state == ST_DIV,
        r_rem < r_period, "divider remainder not below period")
    `CP2RPM_ASSERT_NEXT(a_pair_starts, i_clk, i_rst_n,
        i_in_valid && !o_in_stall && i_on_primary_channel && r_awaiting,
        (r_state == ST_DIV || r_state == ST_HOLD) && !r_awaiting,
        "closing capture did not start a computation")
    `CP2RPM_ASSERT_NEXT(a_hold_loads, i_clk, i_rst_n,
        r_state == ST_HOLD && (!r_out_valid || !i_out_stall),
        o_out_valid && r_state == ST_IDLE, "finished result not loaded")
    `CP2RPM_ASSERT_NOW(a_zero_result, i_clk, i_rst_n, o_out_valid && o_zero_period,
        o_period_ticks == '0 && o_frequency_q8 == '0 && o_speed_rpm_q8 == '0,
        "zero-period result carries nonzero fields")

endmodule
